// File: sv/adsr_envelope_generator_assert.svh
// Assertion helpers; clock and reset names are those of the including module.
`ifndef ADSR_ENVELOPE_GENERATOR_ASSERT_SVH
`define ADSR_ENVELOPE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define ADSR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ADSR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/adsr_pkg.sv
`default_nettype none

package adsr_pkg;

    localparam int LEVEL_W = 10;
    localparam int COUNT_W = 11;
    localparam int NUM_W   = 21;
    localparam int QUOT_W  = 10;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 10'd1023;
    localparam logic [LEVEL_W-1:0] ACCENT_DEN = 10'd10;

    localparam logic [LEVEL_W-1:0] ATTACK_RST  = 10'd50;
    localparam logic [LEVEL_W-1:0] DECAY_RST   = 10'd700;
    localparam logic [LEVEL_W-1:0] SUSTAIN_RST = 10'd300;
    localparam logic [LEVEL_W-1:0] RELEASE_RST = 10'd40;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_INDEX,
        SQ_CURVE,
        SQ_MUL,
        SQ_SCALE,
        SQ_ATTEN,
        SQ_ACCENT,
        SQ_DONE
    } t_seq;

    typedef enum logic [1:0] {
        REG_ATTACK  = 2'd0,
        REG_DECAY   = 2'd1,
        REG_SUSTAIN = 2'd2,
        REG_RELEASE = 2'd3
    } t_reg;

    typedef struct packed {
        logic               start;
        logic [NUM_W-1:0]   numer;
        logic [LEVEL_W-1:0] denom;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_stat;

    localparam logic [LEVEL_W-1:0] CURVE [0:255] = '{
        10'd0, 10'd19, 10'd39, 10'd58, 10'd77, 10'd95, 10'd113, 10'd131, 10'd148, 10'd165,
        10'd182, 10'd198, 10'd214, 10'd230, 10'd245, 10'd260, 10'd275, 10'd289, 10'd304,
        10'd318, 10'd331, 10'd345, 10'd358, 10'd371, 10'd383, 10'd396, 10'd408, 10'd420,
        10'd432, 10'd443, 10'd454, 10'd465, 10'd476, 10'd487, 10'd497, 10'd507, 10'd517,
        10'd527, 10'd537, 10'd546, 10'd556, 10'd565, 10'd574, 10'd582, 10'd591, 10'd599,
        10'd607, 10'd615, 10'd623, 10'd631, 10'd639, 10'd646, 10'd653, 10'd661, 10'd668,
        10'd675, 10'd681, 10'd688, 10'd694, 10'd701, 10'd707, 10'd713, 10'd719, 10'd725,
        10'd731, 10'd737, 10'd742, 10'd748, 10'd753, 10'd758, 10'd763, 10'd768, 10'd773,
        10'd778, 10'd783, 10'd787, 10'd792, 10'd796, 10'd801, 10'd805, 10'd809, 10'd814,
        10'd818, 10'd822, 10'd825, 10'd829, 10'd833, 10'd837, 10'd840, 10'd844, 10'd847,
        10'd851, 10'd854, 10'd857, 10'd861, 10'd864, 10'd867, 10'd870, 10'd873, 10'd876,
        10'd879, 10'd881, 10'd884, 10'd887, 10'd889, 10'd892, 10'd894, 10'd897, 10'd899,
        10'd902, 10'd904, 10'd906, 10'd909, 10'd911, 10'd913, 10'd915, 10'd917, 10'd919,
        10'd921, 10'd923, 10'd925, 10'd927, 10'd929, 10'd931, 10'd933, 10'd934, 10'd936,
        10'd938, 10'd939, 10'd941, 10'd943, 10'd944, 10'd946, 10'd947, 10'd949, 10'd950,
        10'd951, 10'd953, 10'd954, 10'd955, 10'd957, 10'd958, 10'd959, 10'd961, 10'd962,
        10'd963, 10'd964, 10'd965, 10'd966, 10'd967, 10'd968, 10'd970, 10'd971, 10'd972,
        10'd973, 10'd974, 10'd974, 10'd975, 10'd976, 10'd977, 10'd978, 10'd979, 10'd980,
        10'd981, 10'd981, 10'd982, 10'd983, 10'd984, 10'd985, 10'd985, 10'd986, 10'd987,
        10'd987, 10'd988, 10'd989, 10'd989, 10'd990, 10'd991, 10'd991, 10'd992, 10'd993,
        10'd993, 10'd994, 10'd994, 10'd995, 10'd995, 10'd996, 10'd996, 10'd997, 10'd997,
        10'd998, 10'd998, 10'd999, 10'd999, 10'd1000, 10'd1000, 10'd1001, 10'd1001,
        10'd1001, 10'd1002, 10'd1002, 10'd1003, 10'd1003, 10'd1003, 10'd1004, 10'd1004,
        10'd1004, 10'd1005, 10'd1005, 10'd1006, 10'd1006, 10'd1006, 10'd1006, 10'd1007,
        10'd1007, 10'd1007, 10'd1008, 10'd1008, 10'd1008, 10'd1009, 10'd1009, 10'd1009,
        10'd1009, 10'd1010, 10'd1010, 10'd1010, 10'd1010, 10'd1011, 10'd1011, 10'd1011,
        10'd1011, 10'd1011, 10'd1012, 10'd1012, 10'd1012, 10'd1012, 10'd1012, 10'd1013,
        10'd1013, 10'd1013, 10'd1013, 10'd1013, 10'd1014, 10'd1014, 10'd1014, 10'd1014,
        10'd1014, 10'd1014, 10'd1015, 10'd1015, 10'd1015, 10'd1015, 10'd1015, 10'd1015,
        10'd1015, 10'd1016
    };

endpackage

`default_nettype wire

// File: sv/adsr_if.sv
`default_nettype none

interface adsr_in_if;
    logic valid;
    logic ready;
    logic action;
    logic gate_level;
    logic accent_off;
    logic vca_gate_mode;

    modport source (output valid, output action, output gate_level,
                    output accent_off, output vca_gate_mode, input ready);
    modport sink   (input valid, input action, input gate_level,
                    input accent_off, input vca_gate_mode, output ready);
endinterface

interface adsr_out_if;
    logic       valid;
    logic       ready;
    logic [9:0] vca_level;
    logic [9:0] vcf_level;

    modport source (output valid, output vca_level, output vcf_level, input ready);
    modport sink   (input valid, input vca_level, input vcf_level, output ready);
endinterface

`default_nettype wire

// File: sv/adsr_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle; needs numer < denom * 2**QUOT_W
module adsr_div (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire adsr_pkg::t_div_req i_req,
    output adsr_pkg::t_div_stat   o_stat
);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [adsr_pkg::NUM_W-1:0]    r_rem, n_rem;
    logic [adsr_pkg::NUM_W-1:0]    r_dsh, n_dsh;
    logic [adsr_pkg::QUOT_W-1:0]   r_q, n_q;
    logic [3:0]                    r_step, n_step;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_q    = r_q;
        n_step = r_step;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_rem  = i_req.numer;
            n_dsh  = {2'b00, i_req.denom, 9'b0};
            n_q    = '0;
            n_step = '0;
        end else if (r_busy) begin
            if (r_rem >= r_dsh) begin
                n_rem = r_rem - r_dsh;
                n_q   = {r_q[adsr_pkg::QUOT_W-2:0], 1'b1};
            end else begin
                n_q   = {r_q[adsr_pkg::QUOT_W-2:0], 1'b0};
            end
            n_dsh = r_dsh >> 1;
            if (r_step == 4'(adsr_pkg::QUOT_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_step = r_step + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_q    <= n_q;
        r_step <= n_step;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.quot = r_q;

endmodule

`default_nettype wire

// File: sv/adsr_envelope_generator.sv
// ADSR envelope generator.
// i_in carries one item per transfer: a timer tick (action 0) or a gate edge
// (action 1 with gate_level). A gate edge is absorbed in the idle state and
// gives no result. Every tick gives one result on o_out: vca_level and vcf_level.
// Registers attack_time, decay_time, sustain_level, release_time sit on the
// APB port at byte addresses 0, 4, 8, 12; pready is always high.
// One tick is worked at a time. Idle, sustain and phase-end ticks skip the
// curve steps; attack ticks run a 10-step curve index division; decay and
// release ticks add a 10-step shift-add multiply and a 10-step divide by full
// scale. Accent adds a divide by 10; all divisions share one serial divider.
// i_in.ready is high only between ticks. The result sits in an output register;
// if o_out stalls, the next tick is taken but its result waits for the slot.
// Reset (synchronous, active low) restores register defaults, phase idle,
// level, counter and gate off, and drops o_out.valid.
`default_nettype none

module adsr_envelope_generator (
    input  wire              i_clk,
    input  wire              i_rst_n,
    adsr_in_if.sink          i_in,
    adsr_out_if.source       o_out,
    input  wire              psel,
    input  wire              penable,
    input  wire              pwrite,
    input  wire  [3:0]       paddr,
    input  wire  [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int LW = adsr_pkg::LEVEL_W;
    localparam int CW = adsr_pkg::COUNT_W;
    localparam int NW = adsr_pkg::NUM_W;

    logic [LW-1:0] r_attack, r_decay, r_sustain, r_release;
    adsr_pkg::t_phase r_phase, n_phase;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [LW-1:0] r_env, n_env;
    logic [LW-1:0] r_rs, n_rs;
    logic          r_gate, n_gate;

    adsr_pkg::t_seq r_seq, n_seq;
    logic          r_acc, n_acc;
    logic          r_mode, n_mode;
    logic          r_div_go, n_div_go;
    logic [LW-1:0] r_curve, n_curve;
    logic [19:0]   r_ma, n_ma;
    logic [LW-1:0] r_mb, n_mb;
    logic [19:0]   r_prod, n_prod;
    logic [3:0]    r_mstep, n_mstep;
    logic [LW-1:0] r_lvl, n_lvl;
    logic          r_out_valid, n_out_valid;
    logic [LW-1:0] r_vca, n_vca;
    logic [LW-1:0] r_vcf, n_vcf;

    logic          w_in_xfer, w_tick, w_gate_ev, w_run, w_load;
    logic [LW-1:0] w_time;
    adsr_pkg::t_div_req  w_div_req;
    adsr_pkg::t_div_stat w_div_stat;

    adsr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_stat  (w_div_stat)
    );

    // configuration
    assign pready = 1'b1;

    always_comb begin
        case (adsr_pkg::t_reg'(paddr[3:2]))
            adsr_pkg::REG_ATTACK:  prdata = {22'b0, r_attack};
            adsr_pkg::REG_DECAY:   prdata = {22'b0, r_decay};
            adsr_pkg::REG_SUSTAIN: prdata = {22'b0, r_sustain};
            adsr_pkg::REG_RELEASE: prdata = {22'b0, r_release};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= adsr_pkg::ATTACK_RST;
            r_decay   <= adsr_pkg::DECAY_RST;
            r_sustain <= adsr_pkg::SUSTAIN_RST;
            r_release <= adsr_pkg::RELEASE_RST;
        end else if (psel && penable && pwrite) begin
            case (adsr_pkg::t_reg'(paddr[3:2]))
                adsr_pkg::REG_ATTACK:  r_attack  <= pwdata[LW-1:0];
                adsr_pkg::REG_DECAY:   r_decay   <= pwdata[LW-1:0];
                adsr_pkg::REG_SUSTAIN: r_sustain <= pwdata[LW-1:0];
                adsr_pkg::REG_RELEASE: r_release <= pwdata[LW-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    assign i_in.ready  = (r_seq == adsr_pkg::SQ_IDLE);
    assign w_in_xfer   = i_in.valid && i_in.ready;
    assign w_tick      = w_in_xfer && !i_in.action;
    assign w_gate_ev   = w_in_xfer && i_in.action;
    assign w_load      = (r_seq == adsr_pkg::SQ_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        case (r_phase)
            adsr_pkg::PH_ATTACK:  w_time = r_attack;
            adsr_pkg::PH_DECAY:   w_time = r_decay;
            adsr_pkg::PH_RELEASE: w_time = r_release;
            default:              w_time = '0;
        endcase
    end
    assign w_run = (w_time != '0) && (r_cnt < {1'b0, w_time});

    // divider operands
    always_comb begin
        w_div_req.start = r_div_go;
        case (r_seq)
            adsr_pkg::SQ_INDEX: begin
                w_div_req.numer = NW'({r_cnt, 8'h00}) - NW'(r_cnt);
                w_div_req.denom = w_time;
            end
            adsr_pkg::SQ_SCALE: begin
                w_div_req.numer = NW'(r_prod);
                w_div_req.denom = adsr_pkg::LEVEL_MAX;
            end
            default: begin
                w_div_req.numer = NW'({r_env, 3'b000}) - NW'(r_env);
                w_div_req.denom = adsr_pkg::ACCENT_DEN;
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            adsr_pkg::SQ_IDLE:
                if (w_tick) n_seq = w_run ? adsr_pkg::SQ_INDEX : adsr_pkg::SQ_ATTEN;
            adsr_pkg::SQ_INDEX:
                if (w_div_stat.done) n_seq = adsr_pkg::SQ_CURVE;
            adsr_pkg::SQ_CURVE:
                n_seq = (r_phase == adsr_pkg::PH_ATTACK) ? adsr_pkg::SQ_ATTEN
                                                         : adsr_pkg::SQ_MUL;
            adsr_pkg::SQ_MUL:
                if (r_mstep == 4'(LW - 1)) n_seq = adsr_pkg::SQ_SCALE;
            adsr_pkg::SQ_SCALE:
                if (w_div_stat.done) n_seq = adsr_pkg::SQ_ATTEN;
            adsr_pkg::SQ_ATTEN:
                n_seq = r_acc ? adsr_pkg::SQ_ACCENT : adsr_pkg::SQ_DONE;
            adsr_pkg::SQ_ACCENT:
                if (w_div_stat.done) n_seq = adsr_pkg::SQ_DONE;
            adsr_pkg::SQ_DONE:
                if (w_load) n_seq = adsr_pkg::SQ_IDLE;
            default:
                n_seq = adsr_pkg::SQ_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_env       = r_env;
        n_rs        = r_rs;
        n_gate      = r_gate;
        n_acc       = r_acc;
        n_mode      = r_mode;
        n_div_go    = 1'b0;
        n_curve     = r_curve;
        n_ma        = r_ma;
        n_mb        = r_mb;
        n_prod      = r_prod;
        n_mstep     = r_mstep;
        n_lvl       = r_lvl;
        n_out_valid = r_out_valid && !o_out.ready;
        n_vca       = r_vca;
        n_vcf       = r_vcf;
        case (r_seq)
            adsr_pkg::SQ_IDLE: begin
                if (w_gate_ev) begin
                    n_gate  = i_in.gate_level;
                    n_phase = i_in.gate_level ? adsr_pkg::PH_ATTACK : adsr_pkg::PH_RELEASE;
                    n_cnt   = '0;
                end else if (w_tick) begin
                    n_acc  = i_in.accent_off;
                    n_mode = i_in.vca_gate_mode;
                    if (w_run) begin
                        n_div_go = 1'b1;
                    end else begin
                        case (r_phase)
                            adsr_pkg::PH_IDLE: n_env = '0;
                            adsr_pkg::PH_ATTACK: begin
                                n_phase = adsr_pkg::PH_DECAY;
                                n_cnt   = '0;
                            end
                            adsr_pkg::PH_DECAY: begin
                                n_phase = adsr_pkg::PH_SUSTAIN;
                                n_cnt   = '0;
                            end
                            adsr_pkg::PH_SUSTAIN: begin
                                n_env = r_sustain;
                                n_rs  = r_sustain;
                                n_cnt = '0;
                            end
                            adsr_pkg::PH_RELEASE: begin
                                n_phase = adsr_pkg::PH_IDLE;
                                n_env   = '0;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            adsr_pkg::SQ_INDEX: begin
                if (w_div_stat.done) n_curve = adsr_pkg::CURVE[w_div_stat.quot[7:0]];
            end
            adsr_pkg::SQ_CURVE: begin
                n_prod  = '0;
                n_mstep = '0;
                n_mb    = adsr_pkg::LEVEL_MAX - r_curve;
                if (r_phase == adsr_pkg::PH_ATTACK) begin
                    n_env = r_curve;
                    n_rs  = r_curve;
                end else if (r_phase == adsr_pkg::PH_DECAY) begin
                    n_ma = 20'(adsr_pkg::LEVEL_MAX - r_sustain);
                end else begin
                    n_ma = 20'(r_rs);
                end
            end
            adsr_pkg::SQ_MUL: begin
                if (r_mb[0]) n_prod = r_prod + r_ma;
                n_ma    = r_ma << 1;
                n_mb    = r_mb >> 1;
                n_mstep = r_mstep + 4'd1;
                if (r_mstep == 4'(LW - 1)) n_div_go = 1'b1;
            end
            adsr_pkg::SQ_SCALE: begin
                if (w_div_stat.done) begin
                    if (r_phase == adsr_pkg::PH_DECAY) begin
                        n_env = r_sustain + w_div_stat.quot;
                        n_rs  = r_sustain + w_div_stat.quot;
                    end else begin
                        n_env = w_div_stat.quot;
                    end
                end
            end
            adsr_pkg::SQ_ATTEN: begin
                if (r_cnt != adsr_pkg::COUNT_MAX) n_cnt = r_cnt + 11'd1;
                n_lvl = r_env;
                if (r_acc) n_div_go = 1'b1;
            end
            adsr_pkg::SQ_ACCENT: begin
                if (w_div_stat.done) n_lvl = w_div_stat.quot;
            end
            adsr_pkg::SQ_DONE: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_vcf       = r_lvl;
                    n_vca       = r_mode ? (r_gate ? adsr_pkg::LEVEL_MAX : '0) : r_lvl;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= adsr_pkg::SQ_IDLE;
            r_phase     <= adsr_pkg::PH_IDLE;
            r_cnt       <= '0;
            r_env       <= '0;
            r_rs        <= '0;
            r_gate      <= 1'b0;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_seq       <= n_seq;
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_env       <= n_env;
            r_rs        <= n_rs;
            r_gate      <= n_gate;
            r_div_go    <= n_div_go;
            r_out_valid <= n_out_valid;
        end
        r_acc   <= n_acc;
        r_mode  <= n_mode;
        r_curve <= n_curve;
        r_ma    <= n_ma;
        r_mb    <= n_mb;
        r_prod  <= n_prod;
        r_mstep <= n_mstep;
        r_lvl   <= n_lvl;
        r_vca   <= n_vca;
        r_vcf   <= n_vcf;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.vca_level = r_vca;
    assign o_out.vcf_level = r_vcf;

`include "adsr_envelope_generator_assert.svh"

    `ADSR_ASSERT_NEXT(a_tick_busy, w_tick, !i_in.ready)
    `ADSR_ASSERT_NEXT(a_gate_clears_count, w_gate_ev, r_cnt == '0)
    `ADSR_ASSERT_NOW(a_idle_div_quiet, r_seq == adsr_pkg::SQ_IDLE, !w_div_stat.busy)
    `ADSR_ASSERT_NEXT(a_div_starts, r_div_go, w_div_stat.busy)

endmodule

`default_nettype wire

// File: tb/adsr_envelope_generator_tb.sv
`default_nettype none

module adsr_envelope_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LW = adsr_pkg::LEVEL_W;
    localparam int CW = adsr_pkg::COUNT_W;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES = 3000;

    typedef struct {
        logic action;
        logic gate_level;
        logic accent_off;
        logic vca_gate_mode;
    } t_event;

    typedef struct {
        logic [LW-1:0] vca;
        logic [LW-1:0] vcf;
    } t_levels;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    adsr_in_if  in_ch();
    adsr_out_if out_ch();

    adsr_envelope_generator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 i_clk = ~i_clk;

    t_event  pending_events[$];
    t_levels expected_levels[$];
    int      errors = 0;
    int      cycles = 0;
    int      idle_mode = 0;
    logic    in_xfer = 1'b0;
    logic    hold_req = 1'b0;
    logic    hold_used = 1'b0;
    int      hold_left = 0;

    // envelope shadow state
    logic [LW-1:0]      sh_attack = adsr_pkg::ATTACK_RST;
    logic [LW-1:0]      sh_decay = adsr_pkg::DECAY_RST;
    logic [LW-1:0]      sh_sustain = adsr_pkg::SUSTAIN_RST;
    logic [LW-1:0]      sh_release = adsr_pkg::RELEASE_RST;
    adsr_pkg::t_phase   sh_phase = adsr_pkg::PH_IDLE;
    logic [CW-1:0]      sh_count = '0;
    logic [LW-1:0]      sh_env = '0;
    logic [LW-1:0]      sh_rstart = '0;
    logic               sh_gate = 1'b0;

    function automatic int unsigned curve_lookup(int unsigned cnt, int unsigned span);
        int unsigned idx;
        idx = (cnt * 255) / span;
        if (idx > 255) idx = 255;
        return adsr_pkg::CURVE[idx];
    endfunction

    function automatic int unsigned clip10(int unsigned v);
        return (v > 1023) ? 1023 : v;
    endfunction

    function automatic void advance_envelope(t_event ev);
        int unsigned c;
        int unsigned lvl;
        t_levels r;
        if (ev.action) begin
            sh_gate = ev.gate_level;
            sh_phase = sh_gate ? adsr_pkg::PH_ATTACK : adsr_pkg::PH_RELEASE;
            sh_count = '0;
            return;
        end
        case (sh_phase)
            adsr_pkg::PH_IDLE: sh_env = '0;
            adsr_pkg::PH_ATTACK: begin
                if (sh_count < sh_attack) begin
                    sh_rstart = LW'(clip10(curve_lookup(sh_count, sh_attack)));
                    sh_env = sh_rstart;
                end else begin
                    sh_phase = adsr_pkg::PH_DECAY;
                    sh_count = '0;
                end
            end
            adsr_pkg::PH_DECAY: begin
                if (sh_count < sh_decay) begin
                    c = curve_lookup(sh_count, sh_decay);
                    sh_rstart = LW'(clip10(sh_sustain +
                        ((1023 - sh_sustain) * (1023 - c)) / 1023));
                    sh_env = sh_rstart;
                end else begin
                    sh_phase = adsr_pkg::PH_SUSTAIN;
                    sh_count = '0;
                end
            end
            adsr_pkg::PH_SUSTAIN: begin
                sh_env = sh_sustain;
                sh_rstart = sh_sustain;
                sh_count = '0;
            end
            adsr_pkg::PH_RELEASE: begin
                if (sh_count < sh_release) begin
                    c = curve_lookup(sh_count, sh_release);
                    sh_env = LW'(clip10((sh_rstart * (1023 - c)) / 1023));
                end else begin
                    sh_phase = adsr_pkg::PH_IDLE;
                    sh_env = '0;
                end
            end
            default: ;
        endcase
        if (sh_count < adsr_pkg::COUNT_MAX) sh_count = sh_count + 1'b1;
        lvl = sh_env;
        if (ev.accent_off) lvl = (lvl * 7) / 10;
        r.vcf = LW'(lvl);
        r.vca = ev.vca_gate_mode ? (sh_gate ? adsr_pkg::LEVEL_MAX : '0) : LW'(lvl);
        expected_levels.push_back(r);
    endfunction

    function automatic bit sender_idles();
        if (idle_mode == 1) return $urandom_range(99) < 88;
        if (idle_mode == 3) return $urandom_range(99) < 7;
        return 0;
    endfunction

    function automatic bit receiver_stalls();
        if (idle_mode == 2) return $urandom_range(99) < 88;
        if (idle_mode == 3) return $urandom_range(99) < 7;
        return 0;
    endfunction

    initial begin
        in_ch.valid = 1'b0;
        in_ch.action = 1'b0;
        in_ch.gate_level = 1'b0;
        in_ch.accent_off = 1'b0;
        in_ch.vca_gate_mode = 1'b0;
        out_ch.ready = 1'b0;
    end

    always @(negedge i_clk) begin
        t_event ev;
        if (i_rst_n && (!in_ch.valid || in_xfer)) begin
            if (pending_events.size() > 0 && !sender_idles()) begin
                ev = pending_events.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.action <= ev.action;
                in_ch.gate_level <= ev.gate_level;
                in_ch.accent_off <= ev.accent_off;
                in_ch.vca_gate_mode <= ev.vca_gate_mode;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= i_rst_n && (hold_left == 0) && !receiver_stalls();
    end

    // one long receiver hold-off, on the first request only
    always @(posedge i_clk) begin
        if (hold_req && !hold_used) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        t_event ev;
        t_levels exp_lv;
        cycles <= cycles + 1;
        in_xfer <= in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            ev.action = in_ch.action;
            ev.gate_level = in_ch.gate_level;
            ev.accent_off = in_ch.accent_off;
            ev.vca_gate_mode = in_ch.vca_gate_mode;
            advance_envelope(ev);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_levels.size() == 0) begin
                $display("%0t: unexpected result vca=%0d vcf=%0d", $realtime,
                         out_ch.vca_level, out_ch.vcf_level);
                errors = errors + 1;
            end else begin
                exp_lv = expected_levels.pop_front();
                if (exp_lv.vca !== out_ch.vca_level) begin
                    $display("%0t: vca_level expected %0d actual %0d", $realtime,
                             exp_lv.vca, out_ch.vca_level);
                    errors = errors + 1;
                end
                if (exp_lv.vcf !== out_ch.vcf_level) begin
                    $display("%0t: vcf_level expected %0d actual %0d", $realtime,
                             exp_lv.vcf, out_ch.vcf_level);
                    errors = errors + 1;
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(adsr_pkg::t_reg idx, logic [LW-1:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 4'(idx) << 2;
        pwdata <= 32'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            adsr_pkg::REG_ATTACK:  sh_attack = val;
            adsr_pkg::REG_DECAY:   sh_decay = val;
            adsr_pkg::REG_SUSTAIN: sh_sustain = val;
            default:               sh_release = val;
        endcase
    endtask

    task automatic set_envelope(int a, int d, int s, int r);
        write_reg(adsr_pkg::REG_ATTACK, LW'(a));
        write_reg(adsr_pkg::REG_DECAY, LW'(d));
        write_reg(adsr_pkg::REG_SUSTAIN, LW'(s));
        write_reg(adsr_pkg::REG_RELEASE, LW'(r));
    endtask

    task automatic drain();
        while (pending_events.size() > 0 || in_ch.valid || expected_levels.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_event(bit act, bit gl, bit acc, bit md);
        t_event ev;
        ev.action = act;
        ev.gate_level = gl;
        ev.accent_off = acc;
        ev.vca_gate_mode = md;
        pending_events.push_back(ev);
    endtask

    task automatic add_tick();
        add_event(1'b0, 1'($urandom_range(1)), $urandom_range(3) == 0,
                  $urandom_range(3) == 0);
    endtask

    // note on / ticks / note off / ticks, with occasional noise
    task automatic add_notes(int budget, int max_ticks);
        int n;
        while (budget > 0) begin
            if ($urandom_range(9) == 0) begin
                add_event(1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
                budget--;
            end else begin
                add_event(1'b1, 1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
                n = $urandom_range(max_ticks);
                repeat (n) add_tick();
                add_event(1'b1, 1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
                budget -= n + 2;
                n = $urandom_range(max_ticks);
                repeat (n) add_tick();
                budget -= n;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset defaults
        add_event(0, 1, 1, 1);
        add_event(0, 0, 0, 0);
        add_event(1, 0, 1, 1);
        add_event(0, 1, 0, 1);
        add_event(1, 1, 1, 1);
        add_event(0, 0, 0, 0);
        add_event(0, 1, 1, 0);
        add_event(0, 0, 0, 1);
        add_event(0, 1, 1, 1);
        add_event(1, 0, 0, 0);
        add_event(0, 0, 0, 0);
        add_event(0, 0, 1, 1);
        drain();

        // zero times and full sustain
        set_envelope(0, 0, 1023, 0);
        add_event(1, 1, 0, 0);
        repeat (4) add_event(0, 0, 0, 0);
        add_event(0, 0, 1, 0);
        add_event(1, 0, 0, 0);
        add_event(0, 0, 0, 1);
        add_event(0, 0, 1, 1);
        drain();

        idle_mode = 0;
        add_notes(120, 20);
        drain();

        set_envelope(1, 1, 0, 1);
        idle_mode = 1;
        add_notes(100, 8);
        drain();

        set_envelope(1023, 1023, 0, 1023);
        idle_mode = 2;
        add_notes(80, 30);
        drain();

        set_envelope($urandom_range(15), $urandom_range(15), $urandom_range(1023),
                     $urandom_range(15));
        idle_mode = 3;
        add_notes(120, 40);
        hold_req <= 1'b1;
        drain();
        hold_req <= 1'b0;

        set_envelope($urandom_range(6), $urandom_range(10), 512, $urandom_range(6));
        idle_mode = 0;
        add_notes(150, 25);
        drain();

        set_envelope($urandom_range(40), $urandom_range(40), $urandom_range(1023),
                     $urandom_range(40));
        idle_mode = 3;
        add_notes(130, 60);
        drain();

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
